// ===== src/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcc_pkg
// shared types, codes and constants of the reference counted cache
// ----------------------------------------------------------------------------
package rcc_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int KEY_BITS_DEF  = 32;
    localparam int SIZE_BITS_DEF = 24;

    localparam int BUDGET_W = 28;
    localparam int SEED_W   = 16;
    localparam int REFS_W   = 16;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int USED_W   = 5;
    localparam int CTR_W    = 32;
    localparam int CFG_AW   = 1;

    localparam logic [BUDGET_W-1:0] BUDGET_RST = 28'd16777216;
    localparam logic [BUDGET_W-1:0] MAX28      = 28'hFFFFFFF;
    localparam logic [SEED_W-1:0]   SEED_RST   = 16'd44257;
    localparam logic [SEED_W-1:0]   LFSR_TAPS  = 16'hB400;
    localparam logic [REFS_W-1:0]   REFS_MAX   = 16'hFFFF;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_REF = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REL = 2'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LOADFAIL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FLUSHED  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_BUDGET = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_SEED   = 1'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CHK,
        S_VIC_STEP,
        S_VIC_MOD,
        S_VIC_RD,
        S_VIC_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MISS,
        S_BUDGET,
        S_SHR_CHK,
        S_REL_RD,
        S_REL_UPD,
        S_FL_RD,
        S_FL_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              load;
        logic [SEED_W-1:0] seed;
        logic              step;
    } t_rng_req;

    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] n;
        n = s >> 1;
        if (s[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

// ===== src/refcounted_random_evict_cache_top.sv =====
// ----------------------------------------------------------------------------
// refcounted_random_evict_cache_top
// fully associative cache with reference counts and random replacement
// ----------------------------------------------------------------------------
// steps: a random probe steps the lfsr, runs the reciprocal modulo, reads the
//   slot and checks it; a linear scan step reads the slot and checks it
// throughput: one transaction at a time; the entry store read port and the
//   modulo unit set the pace, stall stays high until the result is queued
// reset: synchronous; valid bits, counters and byte total clear at once,
//   so no clearing pass is needed
module refcounted_random_evict_cache_top #(
    parameter int SLOTS     = rcc_pkg::SLOTS_DEF,
    parameter int KEY_BITS  = rcc_pkg::KEY_BITS_DEF,
    parameter int SIZE_BITS = rcc_pkg::SIZE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [rcc_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [rcc_pkg::BUDGET_W-1:0]  i_cfg_wdata,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rcc_pkg::FUNC_W-1:0]    i_func,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [SIZE_BITS-1:0]          i_load_size,
    input  logic                          i_load_ok,
    input  logic [rcc_pkg::SLOT_W-1:0]    i_slot,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rcc_pkg::STATUS_W-1:0]  o_status,
    output logic [rcc_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [SIZE_BITS-1:0]          o_entry_bytes,
    output logic [rcc_pkg::REFS_W-1:0]    o_entry_refs,
    output logic [rcc_pkg::BUDGET_W-1:0]  o_total_bytes,
    output logic [rcc_pkg::USED_W-1:0]    o_entries_used,
    output logic [rcc_pkg::CTR_W-1:0]     o_hits_total,
    output logic [rcc_pkg::CTR_W-1:0]     o_misses_total
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TOT_W  = SIZE_BITS + CNT_W;
    localparam int CW     = (TOT_W > rcc_pkg::BUDGET_W) ? TOT_W : rcc_pkg::BUDGET_W;
    localparam int EW     = rcc_pkg::BUDGET_W + 1;
    localparam int PROBES = 4 * SLOTS;
    localparam int ATT_W  = $clog2(PROBES + 1);
    localparam int SH_W   = $clog2(PROBES);
    localparam int RW     = rcc_pkg::REFS_W;

    rcc_pkg::t_state r_state, n_state;

    // sequencer registers
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_vic, n_vic;
    logic                 r_vic_ok, n_vic_ok;
    logic [IDX_W-1:0]     r_fresh, n_fresh;
    logic                 r_fresh_ok, n_fresh_ok;
    logic [ATT_W-1:0]     r_att, n_att;
    logic [SH_W-1:0]      r_sh, n_sh;
    logic                 r_shrink, n_shrink;

    // latched request
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic                 r_load_ok, n_load_ok;

    // cache state
    logic [SLOTS-1:0]                 r_valid, n_valid;
    logic [CNT_W-1:0]                 r_count, n_count;
    logic [TOT_W-1:0]                 r_bytes, n_bytes;
    logic [rcc_pkg::CTR_W-1:0]        r_hits, n_hits;
    logic [rcc_pkg::CTR_W-1:0]        r_misses, n_misses;
    logic [rcc_pkg::BUDGET_W-1:0]     r_evict, n_evict;
    logic [CW-1:0]                    r_need, n_need;
    logic [rcc_pkg::BUDGET_W-1:0]     r_budget, n_budget;

    // pending result
    logic [rcc_pkg::STATUS_W-1:0]     r_res_status, n_res_status;
    logic [rcc_pkg::SLOT_W-1:0]       r_res_slot, n_res_slot;
    logic [SIZE_BITS-1:0]             r_res_bytes, n_res_bytes;
    logic [RW-1:0]                    r_res_refs, n_res_refs;

    // output register
    logic                             r_ov, n_ov;
    logic [rcc_pkg::STATUS_W-1:0]     r_o_status, n_o_status;
    logic [rcc_pkg::SLOT_W-1:0]       r_o_slot, n_o_slot;
    logic [SIZE_BITS-1:0]             r_o_bytes, n_o_bytes;
    logic [RW-1:0]                    r_o_refs, n_o_refs;
    logic [rcc_pkg::BUDGET_W-1:0]     r_o_total, n_o_total;
    logic [rcc_pkg::USED_W-1:0]       r_o_used, n_o_used;
    logic [rcc_pkg::CTR_W-1:0]        r_o_hits, n_o_hits;
    logic [rcc_pkg::CTR_W-1:0]        r_o_misses, n_o_misses;

    // entry store and random unit
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [KEY_BITS-1:0]  mem_wkey;
    logic [SIZE_BITS-1:0] mem_wsize;
    logic [RW-1:0]        mem_wrefs;
    logic [KEY_BITS-1:0]  rd_key;
    logic [SIZE_BITS-1:0] rd_size;
    logic [RW-1:0]        rd_refs;
    rcc_pkg::t_rng_req    rng_req;
    logic                 rng_ready;
    logic [IDX_W-1:0]     rng_idx;

    // decision terms
    logic              accept;
    logic              cur_valid;
    logic              last;
    logic              lk_hit;
    logic              fresh_now;
    logic              vic_take;
    logic              over;
    logic              shr_stop;
    logic              slot_ok;
    logic              out_free;
    logic              att_done;
    logic [TOT_W-1:0]  bytes_sub;
    logic [EW-1:0]     evict_sum;
    logic [CW-1:0]     bytes_wide;
    logic [RW-1:0]     rel_refs;
    rcc_pkg::t_state   vic_ret;

    assign accept     = i_in_valid && !o_in_stall;
    assign cur_valid  = r_valid[r_idx];
    assign last       = (r_idx == IDX_W'(SLOTS - 1));
    assign lk_hit     = cur_valid && (rd_key == r_key);
    assign fresh_now  = r_fresh_ok || !cur_valid;
    assign vic_take   = !cur_valid || (rd_refs == '0);
    assign bytes_wide = CW'(r_bytes);
    assign over       = bytes_wide > CW'(r_budget);
    assign shr_stop   = (CW'(r_evict) >= r_need) || (r_sh == SH_W'(PROBES - 1));
    assign slot_ok    = 32'(i_slot) < SLOTS;
    assign out_free   = !r_ov || !i_out_stall;
    assign att_done   = (r_att == ATT_W'(PROBES));
    assign bytes_sub  = r_bytes - TOT_W'(rd_size);
    assign evict_sum  = EW'(r_evict) + EW'(rd_size);
    assign rel_refs   = (cur_valid && rd_refs != '0) ? rd_refs - RW'(1) : '0;
    assign vic_ret    = r_shrink ? rcc_pkg::S_SHR_CHK : rcc_pkg::S_MISS;

    assign o_in_stall = (r_state != rcc_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_func)
                        rcc_pkg::FN_REF: n_state = rcc_pkg::S_LK_RD;
                        rcc_pkg::FN_REL: n_state = slot_ok ? rcc_pkg::S_REL_RD
                                                           : rcc_pkg::S_DONE;
                        default:         n_state = rcc_pkg::S_FL_RD;
                    endcase
                end
            end
            rcc_pkg::S_LK_RD:  n_state = rcc_pkg::S_LK_CHK;
            rcc_pkg::S_LK_CHK: begin
                if (lk_hit) begin
                    n_state = rcc_pkg::S_DONE;
                end else if (last) begin
                    n_state = fresh_now ? rcc_pkg::S_MISS : rcc_pkg::S_VIC_STEP;
                end else begin
                    n_state = rcc_pkg::S_LK_RD;
                end
            end
            rcc_pkg::S_VIC_STEP: n_state = att_done ? rcc_pkg::S_SCAN_RD : rcc_pkg::S_VIC_MOD;
            rcc_pkg::S_VIC_MOD: begin
                if (rng_ready) begin
                    n_state = rcc_pkg::S_VIC_RD;
                end
            end
            rcc_pkg::S_VIC_RD:  n_state = rcc_pkg::S_VIC_CHK;
            rcc_pkg::S_VIC_CHK: n_state = vic_take ? vic_ret : rcc_pkg::S_VIC_STEP;
            rcc_pkg::S_SCAN_RD: n_state = rcc_pkg::S_SCAN_CHK;
            rcc_pkg::S_SCAN_CHK: begin
                if (vic_take || last) begin
                    n_state = vic_ret;
                end else begin
                    n_state = rcc_pkg::S_SCAN_RD;
                end
            end
            rcc_pkg::S_MISS: n_state = (r_vic_ok && r_load_ok) ? rcc_pkg::S_BUDGET
                                                               : rcc_pkg::S_DONE;
            rcc_pkg::S_BUDGET:  n_state = over ? rcc_pkg::S_VIC_STEP : rcc_pkg::S_DONE;
            rcc_pkg::S_SHR_CHK: n_state = shr_stop ? rcc_pkg::S_DONE : rcc_pkg::S_VIC_STEP;
            rcc_pkg::S_REL_RD:  n_state = rcc_pkg::S_REL_UPD;
            rcc_pkg::S_REL_UPD: n_state = rcc_pkg::S_DONE;
            rcc_pkg::S_FL_RD:   n_state = rcc_pkg::S_FL_CHK;
            rcc_pkg::S_FL_CHK:  n_state = last ? rcc_pkg::S_DONE : rcc_pkg::S_FL_RD;
            rcc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rcc_pkg::S_IDLE;
                end
            end
            default: n_state = rcc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs of the sequencer
    always_comb begin
        n_idx        = r_idx;
        n_vic        = r_vic;
        n_vic_ok     = r_vic_ok;
        n_fresh      = r_fresh;
        n_fresh_ok   = r_fresh_ok;
        n_att        = r_att;
        n_sh         = r_sh;
        n_shrink     = r_shrink;
        n_key        = r_key;
        n_size       = r_size;
        n_load_ok    = r_load_ok;
        n_valid      = r_valid;
        n_count      = r_count;
        n_bytes      = r_bytes;
        n_hits       = r_hits;
        n_misses     = r_misses;
        n_evict      = r_evict;
        n_need       = r_need;
        n_budget     = r_budget;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_bytes  = r_res_bytes;
        n_res_refs   = r_res_refs;
        n_ov         = r_ov;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;
        n_o_bytes    = r_o_bytes;
        n_o_refs     = r_o_refs;
        n_o_total    = r_o_total;
        n_o_used     = r_o_used;
        n_o_hits     = r_o_hits;
        n_o_misses   = r_o_misses;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wkey     = rd_key;
        mem_wsize    = rd_size;
        mem_wrefs    = rd_refs;
        rng_req      = '0;

        // result taken downstream
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        // configuration writes must arrive only while idle; the block does not enforce it
        if (i_cfg_we) begin
            case (i_cfg_addr)
                rcc_pkg::CFG_BUDGET: n_budget = i_cfg_wdata;
                rcc_pkg::CFG_SEED: begin
                    rng_req.load = 1'b1;
                    rng_req.seed = (i_cfg_wdata[rcc_pkg::SEED_W-1:0] == '0)
                                 ? rcc_pkg::SEED_W'(1)
                                 : i_cfg_wdata[rcc_pkg::SEED_W-1:0];
                end
                default: ;
            endcase
        end

        case (r_state)
            rcc_pkg::S_IDLE: begin
                if (accept) begin
                    n_key        = i_key;
                    n_size       = i_load_size;
                    n_load_ok    = i_load_ok;
                    n_fresh_ok   = 1'b0;
                    n_shrink     = 1'b0;
                    n_att        = '0;
                    n_idx        = (i_func == rcc_pkg::FN_REL && slot_ok)
                                 ? IDX_W'(i_slot) : '0;
                    n_res_slot   = '0;
                    n_res_bytes  = '0;
                    n_res_refs   = '0;
                    n_res_status = rcc_pkg::ST_FLUSHED;
                    if (i_func == rcc_pkg::FN_REL) begin
                        n_res_status = rcc_pkg::ST_RELEASED;
                        n_res_slot   = i_slot;
                    end
                end
            end
            rcc_pkg::S_LK_CHK: begin
                if (lk_hit) begin
                    mem_we       = 1'b1;
                    mem_wrefs    = (rd_refs == rcc_pkg::REFS_MAX) ? rd_refs : rd_refs + RW'(1);
                    n_hits       = r_hits + 1'b1;
                    n_res_status = rcc_pkg::ST_HIT;
                    n_res_slot   = rcc_pkg::SLOT_W'(r_idx);
                    n_res_bytes  = rd_size;
                    n_res_refs   = mem_wrefs;
                end else begin
                    // remember the first empty slot
                    if (!cur_valid && !r_fresh_ok) begin
                        n_fresh    = r_idx;
                        n_fresh_ok = 1'b1;
                    end
                    if (last) begin
                        if (fresh_now) begin
                            n_vic    = r_fresh_ok ? r_fresh : r_idx;
                            n_vic_ok = 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            rcc_pkg::S_VIC_STEP: begin
                if (att_done) begin
                    n_idx = '0;
                end else begin
                    rng_req.step = 1'b1;
                    n_att        = r_att + 1'b1;
                end
            end
            rcc_pkg::S_VIC_MOD: begin
                if (rng_ready) begin
                    n_idx = rng_idx;
                end
            end
            rcc_pkg::S_VIC_CHK, rcc_pkg::S_SCAN_CHK, rcc_pkg::S_FL_CHK: begin
                if (r_state == rcc_pkg::S_FL_CHK) begin
                    if (!last) begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (vic_take) begin
                    n_vic    = r_idx;
                    n_vic_ok = 1'b1;
                end else if (r_state == rcc_pkg::S_SCAN_CHK) begin
                    if (last) begin
                        n_vic_ok = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                // drop an unreferenced valid entry
                if (cur_valid && rd_refs == '0) begin
                    n_valid[r_idx] = 1'b0;
                    n_count        = r_count - 1'b1;
                    n_bytes        = bytes_sub;
                    n_evict        = (evict_sum > EW'(rcc_pkg::MAX28))
                                   ? rcc_pkg::MAX28 : evict_sum[rcc_pkg::BUDGET_W-1:0];
                end
            end
            rcc_pkg::S_MISS: begin
                if (!r_vic_ok) begin
                    n_res_status = rcc_pkg::ST_NOSLOT;
                end else if (!r_load_ok) begin
                    n_res_status = rcc_pkg::ST_LOADFAIL;
                end else begin
                    mem_we         = 1'b1;
                    mem_waddr      = r_vic;
                    mem_wkey       = r_key;
                    mem_wsize      = r_size;
                    mem_wrefs      = RW'(1);
                    n_valid[r_vic] = 1'b1;
                    n_count        = r_count + 1'b1;
                    n_bytes        = r_bytes + TOT_W'(r_size);
                    n_misses       = r_misses + 1'b1;
                    n_res_status   = rcc_pkg::ST_LOADED;
                    n_res_slot     = rcc_pkg::SLOT_W'(r_vic);
                    n_res_bytes    = r_size;
                    n_res_refs     = RW'(1);
                end
            end
            rcc_pkg::S_BUDGET: begin
                if (over) begin
                    n_need   = bytes_wide - CW'(r_budget);
                    n_evict  = '0;
                    n_sh     = '0;
                    n_att    = '0;
                    n_shrink = 1'b1;
                end
            end
            rcc_pkg::S_SHR_CHK: begin
                if (!shr_stop) begin
                    n_sh  = r_sh + 1'b1;
                    n_att = '0;
                end
            end
            rcc_pkg::S_REL_UPD: begin
                mem_we      = cur_valid;
                mem_wrefs   = rel_refs;
                n_res_bytes = cur_valid ? rd_size : '0;
                n_res_refs  = rel_refs;
            end
            rcc_pkg::S_DONE: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_res_status;
                    n_o_slot   = r_res_slot;
                    n_o_bytes  = r_res_bytes;
                    n_o_refs   = r_res_refs;
                    n_o_total  = (bytes_wide > CW'(rcc_pkg::MAX28))
                               ? rcc_pkg::MAX28 : rcc_pkg::BUDGET_W'(bytes_wide);
                    n_o_used   = rcc_pkg::USED_W'(r_count);
                    n_o_hits   = r_hits;
                    n_o_misses = r_misses;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rcc_pkg::S_IDLE;
            r_valid  <= '0;
            r_count  <= '0;
            r_bytes  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evict  <= '0;
            r_budget <= rcc_pkg::BUDGET_RST;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_evict  <= n_evict;
            r_budget <= n_budget;
            r_ov     <= n_ov;
        end
        r_idx        <= n_idx;
        r_vic        <= n_vic;
        r_vic_ok     <= n_vic_ok;
        r_fresh      <= n_fresh;
        r_fresh_ok   <= n_fresh_ok;
        r_att        <= n_att;
        r_sh         <= n_sh;
        r_shrink     <= n_shrink;
        r_key        <= n_key;
        r_size       <= n_size;
        r_load_ok    <= n_load_ok;
        r_need       <= n_need;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_bytes  <= n_res_bytes;
        r_res_refs   <= n_res_refs;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
        r_o_bytes    <= n_o_bytes;
        r_o_refs     <= n_o_refs;
        r_o_total    <= n_o_total;
        r_o_used     <= n_o_used;
        r_o_hits     <= n_o_hits;
        r_o_misses   <= n_o_misses;
    end

    rcc_mem #(
        .SLOTS     (SLOTS),
        .KEY_BITS  (KEY_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wkey  (mem_wkey),
        .i_wsize (mem_wsize),
        .i_wrefs (mem_wrefs),
        .i_raddr (r_idx),
        .o_rkey  (rd_key),
        .o_rsize (rd_size),
        .o_rrefs (rd_refs)
    );

    rcc_rng #(
        .SLOTS (SLOTS)
    ) u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rng_req),
        .o_ready (rng_ready),
        .o_idx   (rng_idx)
    );

    assign o_out_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_slot_out     = r_o_slot;
    assign o_entry_bytes  = r_o_bytes;
    assign o_entry_refs   = r_o_refs;
    assign o_total_bytes  = r_o_total;
    assign o_entries_used = r_o_used;
    assign o_hits_total   = r_o_hits;
    assign o_misses_total = r_o_misses;

endmodule

// ===== src/rcc_mem.sv =====
// ----------------------------------------------------------------------------
// rcc_mem
// entry store: key, byte size and reference count, one write and one read port
// ----------------------------------------------------------------------------
module rcc_mem #(
    parameter int SLOTS     = rcc_pkg::SLOTS_DEF,
    parameter int KEY_BITS  = rcc_pkg::KEY_BITS_DEF,
    parameter int SIZE_BITS = rcc_pkg::SIZE_BITS_DEF,
    localparam int IDX_W    = $clog2(SLOTS)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [IDX_W-1:0]          i_waddr,
    input  logic [KEY_BITS-1:0]       i_wkey,
    input  logic [SIZE_BITS-1:0]      i_wsize,
    input  logic [rcc_pkg::REFS_W-1:0] i_wrefs,
    input  logic [IDX_W-1:0]          i_raddr,
    output logic [KEY_BITS-1:0]       o_rkey,
    output logic [SIZE_BITS-1:0]      o_rsize,
    output logic [rcc_pkg::REFS_W-1:0] o_rrefs
);

    logic [KEY_BITS-1:0]        r_key  [SLOTS];
    logic [SIZE_BITS-1:0]       r_size [SLOTS];
    logic [rcc_pkg::REFS_W-1:0] r_refs [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key[i_waddr]  <= i_wkey;
            r_size[i_waddr] <= i_wsize;
            r_refs[i_waddr] <= i_wrefs;
        end
        o_rkey  <= r_key[i_raddr];
        o_rsize <= r_size[i_raddr];
        o_rrefs <= r_refs[i_raddr];
    end

endmodule

// ===== src/rcc_rng.sv =====
// ----------------------------------------------------------------------------
// rcc_rng
// replacement lfsr with a reciprocal multiply and a remainder step giving the probe slot
// ----------------------------------------------------------------------------
module rcc_rng #(
    parameter int SLOTS  = rcc_pkg::SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcc_pkg::t_rng_req i_req,
    output logic              o_ready,
    output logic [IDX_W-1:0]  o_idx
);

    // ceil(2^32 / slots) gives an exact quotient for every 16-bit value
    localparam logic [31:0] RECIP =
        32'(((64'd1 << 32) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
    localparam logic [rcc_pkg::SEED_W-1:0] DIV = rcc_pkg::SEED_W'(SLOTS);

    logic [rcc_pkg::SEED_W-1:0] r_lfsr, n_lfsr;
    logic [1:0]                 r_cnt, n_cnt;
    logic [rcc_pkg::SEED_W-1:0] r_q, n_q;
    logic [IDX_W-1:0]           r_rem, n_rem;
    logic [47:0]                prod;
    logic [rcc_pkg::SEED_W-1:0] qd;
    logic [rcc_pkg::SEED_W-1:0] rem_full;

    assign prod     = 48'(r_lfsr) * 48'(RECIP);
    assign qd       = r_q * DIV;
    assign rem_full = r_lfsr - qd;

    always_comb begin
        n_lfsr = r_lfsr;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_req.load) begin
            n_lfsr = i_req.seed;
        end else if (i_req.step) begin
            n_lfsr = rcc_pkg::lfsr_step(r_lfsr);
            n_cnt  = 2'd2;
        end else if (r_cnt == 2'd2) begin
            // quotient by reciprocal multiply
            n_q   = prod[47:32];
            n_cnt = 2'd1;
        end else if (r_cnt == 2'd1) begin
            // remainder from the quotient
            n_rem = rem_full[IDX_W-1:0];
            n_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= rcc_pkg::SEED_RST;
            r_cnt  <= '0;
        end else begin
            r_lfsr <= n_lfsr;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_ready = (r_cnt == 2'd0);
    assign o_idx   = r_rem;

endmodule

// ===== src/rcc_checker.sv =====
// ----------------------------------------------------------------------------
// rcc_checker
// port level checks of the reference counted cache
// ----------------------------------------------------------------------------
module rcc_port_checks #(
    parameter int SLOTS = rcc_pkg::SLOTS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [rcc_pkg::STATUS_W-1:0] o_status,
    input logic [rcc_pkg::REFS_W-1:0]   o_entry_refs,
    input logic [rcc_pkg::USED_W-1:0]   o_entries_used
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    // one transaction at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= rcc_pkg::ST_FLUSHED)
        else $error("status code out of range");

    // a hit or a load always leaves the entry referenced
    a_refs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == rcc_pkg::ST_HIT || o_status == rcc_pkg::ST_LOADED)
        |-> o_entry_refs != '0)
        else $error("referenced entry without references");

    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_entries_used) <= SLOTS)
        else $error("more entries than slots");

endmodule

bind refcounted_random_evict_cache_top rcc_port_checks #(.SLOTS(SLOTS)) u_rcc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_entry_refs   (o_entry_refs),
    .o_entries_used (o_entries_used)
);
